// ===== rtl/sha256_stream_hasher_top_macros.svh =====
// assertion macros shared by the checker
`ifndef SHA256_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_STREAM_HASHER_TOP_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
// next-cycle implication checked outside reset
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

// ===== rtl/sha_pkg.sv =====
// shared types, constants and functions of the sha-256 stream hasher
`default_nettype none
package sha_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned PartW = 64;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_EMIT
  } ctl_state_t;

  // byte source for the datapath byte loader
  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN
  } byte_src_t;

  typedef struct packed {
    logic       push;       // write one byte into the block
    byte_src_t  src;
    logic       count_len;  // increment message length
    logic       comp_start; // load working vars from chain
    logic       comp_round; // run one round
    logic       comp_end;   // fold working vars into chain
    logic       clear;      // return to reset values
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] byte_pos;
    logic [6:0] round;
  } dp_stat_t;

  typedef logic [WordW-1:0] word_t;

  localparam word_t InitChain [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundConst [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,32'h923f82a4,
    32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,32'h72be5d74,32'h80deb1fe,
    32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,
    32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
    32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,
    32'h53380d13,32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,32'h19a4c116,
    32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
    32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,32'h90befffa,32'ha4506ceb,32'hbef9a3f7,
    32'hc67178f2
  };

  function automatic word_t rotr(input word_t v, input int unsigned s);
    rotr = (v >> s) | (v << (WordW - s));
  endfunction
endpackage
`default_nettype wire

// ===== rtl/sha_stream_if.sv =====
// valid/ready channel interfaces for input bytes and digest parts
`default_nettype none
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       is_last;
  modport source (output valid, data_byte, has_byte, is_last, input ready);
  modport sink (input valid, data_byte, has_byte, is_last, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_part;
  logic [1:0]  part_index;
  logic        last_part;
  modport source (output valid, digest_part, part_index, last_part, input ready);
  modport sink (input valid, digest_part, part_index, last_part, output ready);
endinterface
`default_nettype wire

// ===== rtl/sha_datapath.sv =====
// sha-256 datapath: block window, round unit, chaining words and length
`default_nettype none
module sha_datapath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sha_pkg::dp_cmd_t cmd,
  input  wire logic [7:0]       data_byte,
  input  wire logic [1:0]       part_sel,
  output sha_pkg::dp_stat_t     stat,
  output logic [63:0]           part_data
);
  import sha_pkg::*;

  word_t       chain_r [8];
  word_t       chain_nxt [8];
  word_t       wv_r [8];
  word_t       wv_nxt [8];
  word_t       win_r [16];
  logic [5:0]  pos_r;
  logic [60:0] len_r;
  logic [6:0]  rnd_r;
  logic [7:0]  byte_v;
  logic [63:0] bits;
  logic [3:0]  t;
  word_t       w15, w2, w_val, s0, s1, t1, t2, big0, big1, ch, maj;
  logic [1:0]  bsel;

  assign bits = {len_r, 3'b000};
  assign bsel = pos_r[1:0];

  always_comb begin
    unique case (cmd.src)
      SRC_DATA: byte_v = data_byte;
      SRC_PAD:  byte_v = PadByte;
      SRC_ZERO: byte_v = 8'h00;
      SRC_LEN:  byte_v = bits[8*(7 - pos_r[2:0]) +: 8];
      default:  byte_v = 8'h00;
    endcase
  end

  // one round of compression with the rolling schedule
  always_comb begin
    t    = rnd_r[3:0];
    w15  = win_r[t + 4'd1];
    w2   = win_r[t + 4'd14];
    s0   = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    s1   = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    w_val = (rnd_r < 7'd16) ? win_r[t] : win_r[t] + s0 + win_r[t + 4'd9] + s1;
    big1 = rotr(wv_r[4], 6) ^ rotr(wv_r[4], 11) ^ rotr(wv_r[4], 25);
    ch   = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
    t1   = wv_r[7] + big1 + ch + RoundConst[rnd_r[5:0]] + w_val;
    big0 = rotr(wv_r[0], 2) ^ rotr(wv_r[0], 13) ^ rotr(wv_r[0], 22);
    maj  = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
    t2   = big0 + maj;
    wv_nxt[0] = t1 + t2;
    wv_nxt[1] = wv_r[0];
    wv_nxt[2] = wv_r[1];
    wv_nxt[3] = wv_r[2];
    wv_nxt[4] = wv_r[3] + t1;
    wv_nxt[5] = wv_r[4];
    wv_nxt[6] = wv_r[5];
    wv_nxt[7] = wv_r[6];
    for (int i = 0; i < 8; i++) chain_nxt[i] = chain_r[i] + wv_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= InitChain[i];
        wv_r[i] <= '0;
      end
      pos_r <= '0;
      len_r <= '0;
      rnd_r <= '0;
    end else begin
      if (cmd.count_len) len_r <= len_r + 61'd1;
      if (cmd.push) begin
        if (bsel == 2'd0) win_r[pos_r[5:2]] <= {byte_v, 24'h0};
        else win_r[pos_r[5:2]][8*(3 - bsel) +: 8] <= byte_v;
        pos_r <= pos_r + 6'd1;
      end
      if (cmd.comp_start) begin
        for (int i = 0; i < 8; i++) wv_r[i] <= chain_r[i];
        rnd_r <= '0;
      end
      if (cmd.comp_round) begin
        for (int i = 0; i < 8; i++) wv_r[i] <= wv_nxt[i];
        win_r[t] <= w_val;
        rnd_r <= rnd_r + 7'd1;
      end
      if (cmd.comp_end) begin
        for (int i = 0; i < 8; i++) chain_r[i] <= chain_nxt[i];
        rnd_r <= '0;
      end
    end
  end

  assign stat.byte_pos = pos_r;
  assign stat.round = rnd_r;
  assign part_data = {chain_r[{part_sel, 1'b0}], chain_r[{part_sel, 1'b1}]};
endmodule
`default_nettype wire

// ===== rtl/sha_ctrl.sv =====
// sha-256 controller: byte intake, padding, compression and digest output
`default_nettype none
module sha_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_has_byte,
  input  wire logic              in_is_last,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             part_sel,
  output logic                   last_part,
  output sha_pkg::dp_cmd_t       cmd,
  input  wire sha_pkg::dp_stat_t stat
);
  import sha_pkg::*;

  ctl_state_t state_r, state_nxt;
  ctl_state_t ret_r, ret_nxt;   // where to go after a compression
  logic [1:0] part_r, part_nxt;
  logic       ending_r, ending_nxt;
  logic       wrap_r, wrap_nxt;  // zero fill runs past the end of this block

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r <= ST_IDLE;
      part_r <= '0;
      ending_r <= 1'b0;
      wrap_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      part_r <= part_nxt;
      ending_r <= ending_nxt;
      wrap_r <= wrap_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    part_nxt = part_r;
    ending_nxt = ending_r;
    wrap_nxt = wrap_r;
    cmd = '0;
    cmd.src = SRC_DATA;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_has_byte) begin
            cmd.push = 1'b1;
            cmd.count_len = 1'b1;
          end
          if (in_has_byte && stat.byte_pos == 6'd63) begin
            cmd.comp_start = 1'b1;
            state_nxt = ST_COMP;
            ret_nxt = in_is_last ? ST_PAD : ST_IDLE;
          end else if (in_is_last) begin
            state_nxt = ST_PAD;
          end
          ending_nxt = in_is_last;
        end
      end
      ST_PAD: begin
        // the 0x80 byte
        cmd.push = 1'b1;
        cmd.src = SRC_PAD;
        // no room left for the length after the pad byte
        wrap_nxt = (stat.byte_pos >= LenPos) && (stat.byte_pos != 6'd63);
        if (stat.byte_pos == 6'd63) begin
          cmd.comp_start = 1'b1;
          state_nxt = ST_COMP;
          ret_nxt = ST_LEN;
        end else begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        // zero fill up to the length field, then eight length bytes
        cmd.push = 1'b1;
        cmd.src = (stat.byte_pos >= LenPos && !wrap_r) ? SRC_LEN : SRC_ZERO;
        if (stat.byte_pos == 6'd63) begin
          cmd.comp_start = 1'b1;
          state_nxt = ST_COMP;
          ret_nxt = wrap_r ? ST_LEN : ST_EMIT;
          wrap_nxt = 1'b0;
        end
      end
      ST_COMP: begin
        if (stat.round == 7'd64) begin
          cmd.comp_end = 1'b1;
          state_nxt = ret_r;
          part_nxt = '0;
        end else begin
          cmd.comp_round = 1'b1;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          part_nxt = part_r + 2'd1;
          if (part_r == 2'd3) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
            ending_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign part_sel = part_r;
  assign last_part = (part_r == 2'd3) && ending_r;
endmodule
`default_nettype wire

// ===== rtl/sha256_stream_hasher_top.sv =====
// sha-256 stream hasher: top level joining controller and datapath
// Usage: feed message bytes one per transfer on in_ (data_byte, has_byte,
// is_last). An item with has_byte low and is_last low does nothing; is_last
// ends the message and may come with or without a byte.
// Ordinary bytes go in one per cycle; the byte that fills a 64-byte block
// holds the input while the round unit runs 64 rounds, one per cycle, and
// then folds the working variables into the chaining words.
// On is_last the controller writes the pad, zero fill and 64-bit bit length
// one byte per cycle outside its one or two compressions, then offers the
// digest on out_ as four 64-bit parts, part_index 0 first, last_part high
// on part 3. Input is not taken while the digest is offered.
// A receiver stall holds the current part; nothing is lost.
// Reset (rst_n low, synchronous) loads the standard initial chaining values
// and clears the length and counters, leaving the controller idle and ready.
// After the last part the datapath is cleared as by reset; control is idle.
`default_nettype none
module sha256_stream_hasher_top (
  input wire logic clk,
  input wire logic rst_n,
  sha_in_if.sink   in_ch,
  sha_out_if.source out_ch
);
  import sha_pkg::*;

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [1:0] part_sel;
  logic       last_part;

  sha_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_has_byte(in_ch.has_byte), .in_is_last(in_ch.is_last),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .part_sel, .last_part, .cmd, .stat
  );

  sha_datapath u_dp (
    .clk, .rst_n, .cmd, .data_byte(in_ch.data_byte), .part_sel, .stat,
    .part_data(out_ch.digest_part)
  );

  assign out_ch.part_index = part_sel;
  assign out_ch.last_part = last_part;
endmodule
`default_nettype wire

// ===== rtl/sha_checker.sv =====
// port-level checker for the sha-256 stream hasher, bound to the top level
`default_nettype none
`include "sha256_stream_hasher_top_macros.svh"
module sha_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  part_index,
  input wire logic        last_part
);
  `SHA_ASSERT_IMP(a_no_in_while_out, clk, rst_n, out_valid, !in_ready)
  `SHA_ASSERT_IMP(a_last_on_three, clk, rst_n, out_valid, last_part == (part_index == 2'd3))
  `SHA_ASSERT_NXT(a_part_advance, clk, rst_n,
    out_valid && out_ready && part_index != 2'd3,
    out_valid && part_index == $past(part_index) + 2'd1)
  `SHA_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(part_index))
endmodule

bind sha256_stream_hasher_top sha_checker u_sha_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .part_index(out_ch.part_index), .last_part(out_ch.last_part)
);
`default_nettype wire
